// ----- rtl/dsgb_pkg.sv -----
// ----------------------------------------------------------------------------
// dsgb_pkg
// Shared constants and types for the degree sequence graph builder.
// ----------------------------------------------------------------------------
package dsgb_pkg;

  // width of one requested degree
  localparam int DEG_W = 8;

  // default size of the degree store
  localparam int DEFAULT_MAX_VERTICES = 8;

  // terminator status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_DEG_BIG  = 2'd1;
  localparam status_t STAT_TOO_FEW  = 2'd2;
  localparam status_t STAT_TOO_MANY = 2'd3;

  // control from the sequencer to the ranking unit
  typedef struct packed {
    logic start;  // first candidate of a scan
    logic step;   // a candidate is presented this cycle
  } scan_ctrl_t;

endpackage

// ----- rtl/degree_sequence_graph_builder_top.sv -----
// ----------------------------------------------------------------------------
// degree_sequence_graph_builder_top
// Havel-Hakimi graph construction from a stream of vertex degrees.
// ----------------------------------------------------------------------------
// Degrees are loaded one request per cycle, numbered from vertex 0 in load
// order; the request with tlast set loads its degree and starts construction
// (past the store size it goes straight to the terminator), and the input
// stays not ready until the run's terminator is produced. Each selection (the
// round's top vertex, or one neighbor) is a scan over all n loaded vertices
// through the single shared compare unit followed by a decision state; a
// neighbor decision waits while the output is stalled. Each edge result
// carries tuser = 1; the terminator carries tuser = 0, tlast = 1 and the
// status (ok, degree too large, not enough vertices, too many vertices).
// Edges sent before an error are not withdrawn.
module degree_sequence_graph_builder_top
  import dsgb_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES,
  localparam int IW = $clog2(MAX_VERTICES),
  localparam int CW = $clog2(MAX_VERTICES + 1),
  localparam int DW = ((2 * IW + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // slave side: degree requests
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DEG_W-1:0] s_axis_tdata,   // [7:0] degree
  input  logic             s_axis_tlast,   // last_degree
  // master side: edges and terminator
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DW-1:0]    m_axis_tdata,   // edge_u, edge_v, status, zero fill
  output logic             m_axis_tuser,   // edge_valid
  output logic             m_axis_tlast    // last
);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_TERM   = 2'd3;

  logic [1:0]             state;
  logic [CW-1:0]          vertex_count;
  logic                   overflow_flag;
  logic [DEG_W-1:0]       deg_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] picked;
  logic [IW-1:0]          idx;
  logic                   round_mode;
  logic [IW-1:0]          u_idx;
  logic [DEG_W-1:0]       remaining;
  status_t                term_status;

  logic [IW-1:0]          out_u;
  logic [IW-1:0]          out_v;
  status_t                out_status;

  scan_ctrl_t             ctrl;
  logic [DEG_W-1:0]       best_deg;
  logic [IW-1:0]          best_idx;
  logic                   best_found;

  logic                   in_acc;
  logic                   out_free;
  logic                   store_full;
  logic                   scan_end;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign store_full    = (vertex_count == CW'(MAX_VERTICES));
  assign scan_end      = ((CW'(idx) + CW'(1)) == vertex_count);

  // shared compare unit
  assign ctrl = '{start: (state == S_SCAN) && (idx == '0), step: (state == S_SCAN)};

  dsgb_rank_unit #(
    .IW (IW)
  ) u_rank (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cand_deg   (deg_mem[idx]),
    .cand_idx   (idx),
    .cand_ok    (~picked[idx]),
    .best_deg   (best_deg),
    .best_idx   (best_idx),
    .best_found (best_found)
  );

  // sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vertex_count  <= '0;
      overflow_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!store_full) begin
              vertex_count <= vertex_count + CW'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
            if (s_axis_tlast) begin
              state <= (overflow_flag || store_full) ? S_TERM : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (round_mode) begin
            if (best_deg == '0 || best_deg >= DEG_W'(vertex_count)) begin
              state <= S_TERM;
            end else begin
              state <= S_SCAN;
            end
          end else if (best_deg == '0) begin
            state <= S_TERM;
          end else if (out_free) begin
            state <= S_SCAN;
          end
        end
        S_TERM: begin
          if (out_free) begin
            state         <= S_IDLE;
            vertex_count  <= '0;
            overflow_flag <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // degree store, scan bookkeeping and round data
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (!store_full) begin
            deg_mem[vertex_count[IW-1:0]] <= s_axis_tdata;
          end
          idx         <= '0;
          round_mode  <= 1'b1;
          picked      <= '0;
          term_status <= STAT_TOO_MANY;
        end
      end
      S_SCAN: begin
        if (!scan_end) begin
          idx <= idx + IW'(1);
        end
      end
      S_DECIDE: begin
        idx <= '0;
        if (round_mode) begin
          if (best_deg == '0) begin
            term_status <= STAT_OK;
          end else if (best_deg >= DEG_W'(vertex_count)) begin
            term_status <= STAT_DEG_BIG;
          end else begin
            // top vertex takes all its edges this round
            u_idx              <= best_idx;
            deg_mem[best_idx]  <= '0;
            picked[best_idx]   <= 1'b1;
            remaining          <= best_deg;
            round_mode         <= 1'b0;
          end
        end else if (best_deg == '0) begin
          term_status <= STAT_TOO_FEW;
        end else if (out_free) begin
          // neighbor used: one degree less, out of this round's ranking
          deg_mem[best_idx] <= best_deg - DEG_W'(1);
          remaining         <= remaining - DEG_W'(1);
          if (remaining == DEG_W'(1)) begin
            round_mode <= 1'b1;
            picked     <= '0;
          end else begin
            picked[best_idx] <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_TERM && out_free) ||
                 (state == S_DECIDE && !round_mode && best_deg != '0 && out_free)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state == S_TERM && out_free) begin
      out_u        <= '0;
      out_v        <= '0;
      out_status   <= term_status;
      m_axis_tuser <= 1'b0;
      m_axis_tlast <= 1'b1;
    end else if (state == S_DECIDE && !round_mode && best_deg != '0 && out_free) begin
      out_u        <= u_idx;
      out_v        <= best_idx;
      out_status   <= STAT_OK;
      m_axis_tuser <= 1'b1;
      m_axis_tlast <= 1'b0;
    end
  end

  assign m_axis_tdata = DW'({out_status, out_v, out_u});

  // a neighbor scan always finds an unused vertex
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && !round_mode) |-> best_found)
    else $error("neighbor scan found no candidate");

  // store count never passes the store size
  assert property (@(posedge clk) disable iff (rst)
    vertex_count <= CW'(MAX_VERTICES))
    else $error("vertex count beyond store size");

  // overflow only once the store is full
  assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> store_full)
    else $error("overflow flag with free store entries");

  // an edge always goes out with neighbors still owed
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && !round_mode) |-> (remaining != '0))
    else $error("neighbor pick with no edges left");

endmodule

// ----- rtl/dsgb_rank_unit.sv -----
// ----------------------------------------------------------------------------
// dsgb_rank_unit
// Shared compare unit: walks the candidates one per cycle while step is set and keeps the
// highest (degree, vertex) key seen; later vertices win ties.
// ----------------------------------------------------------------------------
module dsgb_rank_unit
  import dsgb_pkg::*;
#(
  parameter int IW = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  scan_ctrl_t       ctrl,
  input  logic [DEG_W-1:0] cand_deg,
  input  logic [IW-1:0]    cand_idx,
  input  logic             cand_ok,
  output logic [DEG_W-1:0] best_deg,
  output logic [IW-1:0]    best_idx,
  output logic             best_found
);

  logic found_eff;
  logic take;

  // a new scan forgets the previous winner
  assign found_eff = best_found & ~ctrl.start;

  // candidates arrive in ascending vertex order, so >= gives ties to the later one
  assign take = ctrl.step & cand_ok & (~found_eff | (cand_deg >= best_deg));

  // winner tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (ctrl.step) begin
      best_found <= found_eff | take;
    end
  end

  // winner payload
  always_ff @(posedge clk) begin
    if (take) begin
      best_deg <= cand_deg;
      best_idx <= cand_idx;
    end
  end

endmodule
